@@ hw/rtl/shabc_pkg.sv @@
// shabc_pkg: item types, control struct and SHA-256 constants for the
// block compressor. No dependencies; used by every module in hw/rtl.
package shabc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned HASH_N   = 8;
  localparam int unsigned ROUNDS   = 64;
  localparam int unsigned BLOCK_N  = 16;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t hash_t [HASH_N];

  typedef struct packed {
    logic [31:0] message_word;
    logic        start_message;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  // sequencer -> datapath controls
  typedef struct packed {
    logic shift_word;  // shift a message word into the schedule window
    logic shift_exp;   // shift an expanded word into the window
    logic ld_vars;     // load working variables from hash state
    logic step;        // run one compression round
  } ctrl_t;

  localparam logic [3:0] POS_LAST   = 4'd15;
  localparam logic [3:0] POS_FIRST  = 4'd0;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] IDX_LAST   = 3'd7;

  localparam hash_t INIT_HASH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TAB [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ hw/rtl/sha256_block_compress.sv @@
// sha256_block_compress: top level, sequencer, hash state and digest output.
// Depends on shabc_pkg, shabc_sched and shabc_round.
//
//   channel | ports                        | direction | payload
//   in      | in_valid, in_stall, in_item  | into      | message word + flags
//   out     | out_valid, out_stall, out_item | out of  | digest word + index
//
// Words 1..15 of a block are shifted into the schedule as they are taken.
// The 16th word raises in_stall and starts the round unit, one round a cycle
// for 64 rounds, then the result is added into the hash state.
// With the last flag, eight digest items follow, one a cycle unless stalled.
// in_stall drops after the add, or, if last, once the last digest is taken.
// Synchronous active-low reset sets the initial hash values and position 0.
module sha256_block_compress import shabc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       last_r, last_nxt;
  hash_t      hash_r, hash_nxt;
  hash_t      vars;
  word_t      w_cur;
  ctrl_t      ctrl;
  logic       in_acc, out_acc;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_EMIT);
  assign out_acc   = out_valid && !out_stall;

  assign out_item.digest_word  = hash_r[idx_r];
  assign out_item.digest_index = idx_r;
  assign out_item.digest_last  = (idx_r == IDX_LAST);

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    rnd_nxt         = rnd_r;
    idx_nxt         = idx_r;
    last_nxt        = last_r;
    hash_nxt        = hash_r;
    ctrl            = '0;
    ctrl.shift_word = in_acc;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          pos_nxt = pos_r + 4'd1;
          if (pos_r == POS_FIRST && in_item.start_message) begin
            hash_nxt = INIT_HASH;
          end
          if (pos_r == POS_LAST) begin
            ctrl.ld_vars = 1'b1;
            last_nxt     = in_item.last_block;
            rnd_nxt      = '0;
            state_nxt    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        ctrl.step      = 1'b1;
        ctrl.shift_exp = 1'b1;
        rnd_nxt        = rnd_r + 6'd1;
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int i = 0; i < HASH_N; i++) begin
          hash_nxt[i] = hash_r[i] + vars[i];
        end
        idx_nxt   = '0;
        state_nxt = last_r ? ST_EMIT : ST_LOAD;
      end
      ST_EMIT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      pos_r   <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      last_r  <= 1'b0;
      hash_r  <= INIT_HASH;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
      hash_r  <= hash_nxt;
    end
  end

  shabc_sched u_sched (
    .clk     (clk),
    .ctrl    (ctrl),
    .word_in (in_item.message_word),
    .w_cur   (w_cur)
  );

  shabc_round u_round (
    .clk     (clk),
    .ctrl    (ctrl),
    .hash_in (hash_r),
    .k_in    (K_TAB[rnd_r]),
    .w_in    (w_cur),
    .vars    (vars)
  );

`ifndef ASSERT_OFF
  // the 16th word of a block starts round zero
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && pos_r == POS_LAST) |=> (state_r == ST_RUN && rnd_r == '0))
    else $error("compression did not start on the 16th word");

  // the round unit hands off to the final add after exactly 64 rounds
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && rnd_r == ROUND_LAST) |=> (state_r == ST_FIN))
    else $error("round count overran");

  // a block boundary is always at position zero once compression ends
  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (pos_r == POS_FIRST))
    else $error("word position not wrapped after compression");

  // taking the final digest word frees the input side
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_item.digest_last) |=> (!in_stall && !out_valid))
    else $error("input not released after last digest word");
`endif

endmodule

@@ hw/rtl/shabc_sched.sv @@
// shabc_sched: 16-word message schedule window with in-place expansion.
// Depends on shabc_pkg.
module shabc_sched import shabc_pkg::*; (
  input  logic  clk,
  input  ctrl_t ctrl,
  input  word_t word_in,
  output word_t w_cur
);

  // win_r[0] holds W[t] for the round in flight; W[t+16] enters at the top
  word_t win_r [BLOCK_N];
  word_t win_nxt [BLOCK_N];
  word_t exp_word;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  assign exp_word = win_r[0] + ssig0(win_r[1]) + win_r[9] + ssig1(win_r[14]);
  assign w_cur    = win_r[0];

  always_comb begin
    for (int i = 0; i < BLOCK_N - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[BLOCK_N-1] = ctrl.shift_word ? word_in : exp_word;
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_word || ctrl.shift_exp) begin
      win_r <= win_nxt;
    end
  end

endmodule

@@ hw/rtl/shabc_round.sv @@
// shabc_round: working variables a..h and the shared round unit.
// Depends on shabc_pkg.
module shabc_round import shabc_pkg::*; (
  input  logic  clk,
  input  ctrl_t ctrl,
  input  hash_t hash_in,
  input  word_t k_in,
  input  word_t w_in,
  output hash_t vars
);

  hash_t v_r;
  hash_t v_nxt;
  word_t s0, s1, ch, mj, t1, t2;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  always_comb begin
    s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + k_in + w_in;
    s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + mj;
    v_nxt[7] = v_r[6];
    v_nxt[6] = v_r[5];
    v_nxt[5] = v_r[4];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[3] = v_r[2];
    v_nxt[2] = v_r[1];
    v_nxt[1] = v_r[0];
    v_nxt[0] = t1 + t2;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_vars) begin
      v_r <= hash_in;
    end else if (ctrl.step) begin
      v_r <= v_nxt;
    end
  end

  assign vars = v_r;

endmodule
